### hdl/rbtc_pkg.sv
`default_nettype none

package rbtc_pkg;

  // field widths
  localparam int POS_W    = 64;
  localparam int TIME_W   = 63;
  localparam int PERIOD_W = 32;
  localparam int GUARD_W  = 10;
  localparam int START_W  = 14;
  localparam int LEN_W    = 15;

  localparam logic [GUARD_W-1:0] GUARD_RESET = 10'd64;

  // ring geometry, size is a power of two
  localparam int RING_SAMPLES = 16384;
  localparam int RING_W       = $clog2(RING_SAMPLES);

  // divider: one quotient bit per step
  localparam int DIV_STEPS = TIME_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // job queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EVAL,
    B_SEG2
  } back_state_t;

  // one classified tick
  typedef struct packed {
    logic             zero;
    logic [POS_W-1:0] target;
  } job_t;

endpackage

`default_nettype wire

### hdl/rbtc_div.sv
`default_nettype none

module rbtc_div (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  input  wire  [rbtc_pkg::TIME_W-1:0]         dividend,
  input  wire  [rbtc_pkg::PERIOD_W-1:0]       divisor,
  output logic                                done,
  output logic [rbtc_pkg::TIME_W-1:0]         quotient
);

  logic                              busy;
  logic [rbtc_pkg::DIV_CNT_W-1:0]    cnt;
  logic [rbtc_pkg::PERIOD_W-1:0]     dvsr;
  logic [rbtc_pkg::PERIOD_W-1:0]     rem;
  logic [rbtc_pkg::PERIOD_W-1:0]     rem_next;
  logic [rbtc_pkg::TIME_W-1:0]       quo_next;
  logic [rbtc_pkg::PERIOD_W:0]       shifted;
  logic [rbtc_pkg::PERIOD_W:0]       trial;
  logic                              qbit;

  // one restoring step: shift in the next dividend bit, try to subtract
  always_comb begin
    shifted  = {rem, quotient[rbtc_pkg::TIME_W-1]};
    trial    = shifted - {1'b0, dvsr};
    qbit     = (shifted >= {1'b0, dvsr});
    rem_next = qbit ? trial[rbtc_pkg::PERIOD_W-1:0] : shifted[rbtc_pkg::PERIOD_W-1:0];
    quo_next = {quotient[rbtc_pkg::TIME_W-2:0], qbit};
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == rbtc_pkg::DIV_CNT_W'(rbtc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr     <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= quo_next;
    end
  end

endmodule

`default_nettype wire

### hdl/rbtc_front.sv
`default_nettype none

module rbtc_front (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire  [rbtc_pkg::GUARD_W-1:0]        back_guard,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [rbtc_pkg::TIME_W-1:0]         now_time,
  input  wire  [rbtc_pkg::POS_W-1:0]          origin_position,
  input  wire  [rbtc_pkg::TIME_W-1:0]         origin_time,
  input  wire  [rbtc_pkg::PERIOD_W-1:0]       sample_period,
  input  wire                                 q_full,
  output logic                                q_push,
  output rbtc_pkg::job_t                      q_data
);

  rbtc_pkg::front_state_t            state;
  rbtc_pkg::front_state_t            state_next;
  logic                              accept;
  logic                              div_start;
  logic                              div_done;
  logic [rbtc_pkg::TIME_W-1:0]       quotient;
  logic [rbtc_pkg::TIME_W:0]         time_diff;
  logic [rbtc_pkg::TIME_W-1:0]       elapsed;
  logic [rbtc_pkg::POS_W-1:0]        base;

  assign accept = in_valid && in_ready;

  // elapsed time, zero when now is before the origin
  always_comb begin
    time_diff = {1'b0, now_time} - {1'b0, origin_time};
    elapsed   = time_diff[rbtc_pkg::TIME_W] ? '0 : time_diff[rbtc_pkg::TIME_W-1:0];
  end

  rbtc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (elapsed),
    .divisor  (sample_period),
    .done     (div_done),
    .quotient (quotient)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbtc_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshakes
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    q_push     = 1'b0;
    unique case (state)
      rbtc_pkg::F_IDLE: begin
        // no beat taken while reset holds
        in_ready = !rst;
        if (in_valid && !rst) begin
          if (sample_period == '0) begin
            state_next = rbtc_pkg::F_PUSH;
          end else begin
            div_start  = 1'b1;
            state_next = rbtc_pkg::F_DIV;
          end
        end
      end
      rbtc_pkg::F_DIV: begin
        if (div_done) begin
          state_next = rbtc_pkg::F_PUSH;
        end
      end
      rbtc_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = rbtc_pkg::F_IDLE;
        end
      end
      default: begin
        state_next = rbtc_pkg::F_IDLE;
      end
    endcase
  end

  // job assembly: base position less guard, then add the sample count
  always_ff @(posedge clk) begin
    if (accept) begin
      base <= origin_position - rbtc_pkg::POS_W'(back_guard);
      if (sample_period == '0) begin
        q_data <= '{zero: 1'b1, target: '0};
      end
    end else if (state == rbtc_pkg::F_DIV && div_done) begin
      q_data <= '{zero: 1'b0, target: base + rbtc_pkg::POS_W'(quotient)};
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == rbtc_pkg::F_DIV)
    else $error("divider finished outside the divide state");

  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (state == rbtc_pkg::F_PUSH && !q_full))
    else $error("job pushed into a full queue or from the wrong state");

  a_start_div: assert property (@(posedge clk) disable iff (rst)
    (accept && sample_period != '0) |=> state == rbtc_pkg::F_DIV)
    else $error("tick with known period did not start a division");

endmodule

`default_nettype wire

### hdl/rbtc_queue.sv
`default_nettype none

module rbtc_queue (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 push,
  input  rbtc_pkg::job_t                      wr_data,
  output logic                                full,
  input  wire                                 pop,
  output rbtc_pkg::job_t                      rd_data,
  output logic                                empty
);

  rbtc_pkg::job_t                    entries [rbtc_pkg::QUEUE_DEPTH];
  logic [rbtc_pkg::QPTR_W-1:0]       wr_ptr;
  logic [rbtc_pkg::QPTR_W-1:0]       rd_ptr;
  logic [rbtc_pkg::QCNT_W-1:0]       count;

  assign full    = (count == rbtc_pkg::QCNT_W'(rbtc_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### hdl/rbtc_back.sv
`default_nettype none

module rbtc_back (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 q_empty,
  output logic                                q_pop,
  input  rbtc_pkg::job_t                      q_data,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [rbtc_pkg::START_W-1:0]        seg_start,
  output logic [rbtc_pkg::LEN_W-1:0]          seg_length,
  output logic                                behind,
  output logic                                last_segment
);

  rbtc_pkg::back_state_t             state;
  rbtc_pkg::back_state_t             state_next;
  rbtc_pkg::job_t                    job;
  logic [rbtc_pkg::POS_W-1:0]        cleared;
  logic [rbtc_pkg::POS_W-1:0]        diff;
  logic                              lagging;
  logic [rbtc_pkg::RING_W-1:0]       tgt_idx;
  logic [rbtc_pkg::RING_W-1:0]       clr_idx;
  logic [rbtc_pkg::RING_W-1:0]       seg2_idx;
  logic                              slot_free;
  logic                              emit;
  logic                              upd_cleared;
  logic [rbtc_pkg::RING_W-1:0]       o_start;
  logic [rbtc_pkg::RING_W:0]         o_len;
  logic                              o_behind;
  logic                              o_last;

  assign slot_free = !out_valid || out_ready;

  // distance from cleared point to target, ring indexes
  always_comb begin
    diff    = job.target - cleared;
    lagging = (diff > rbtc_pkg::POS_W'(rbtc_pkg::RING_SAMPLES));
    tgt_idx = job.target[rbtc_pkg::RING_W-1:0];
    clr_idx = cleared[rbtc_pkg::RING_W-1:0];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbtc_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and segment selection
  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    emit        = 1'b0;
    upd_cleared = 1'b0;
    o_start     = '0;
    o_len       = '0;
    o_behind    = 1'b0;
    o_last      = 1'b1;
    unique case (state)
      rbtc_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = rbtc_pkg::B_EVAL;
        end
      end
      rbtc_pkg::B_EVAL: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = rbtc_pkg::B_IDLE;
          priority if (job.zero) begin
            // unknown period: empty segment, state untouched
            o_start = '0;
          end else if (lagging) begin
            upd_cleared = 1'b1;
            o_start     = tgt_idx;
            o_behind    = 1'b1;
          end else if (tgt_idx >= clr_idx) begin
            upd_cleared = 1'b1;
            o_start     = clr_idx;
            o_len       = {1'b0, tgt_idx - clr_idx};
          end else begin
            // range wraps: run to ring end, second beat follows
            upd_cleared = 1'b1;
            o_start     = clr_idx;
            o_len       = (rbtc_pkg::RING_W+1)'(rbtc_pkg::RING_SAMPLES) - {1'b0, clr_idx};
            o_last      = 1'b0;
            state_next  = rbtc_pkg::B_SEG2;
          end
        end
      end
      rbtc_pkg::B_SEG2: begin
        if (slot_free) begin
          emit       = 1'b1;
          o_start    = '0;
          o_len      = {1'b0, seg2_idx};
          state_next = rbtc_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = rbtc_pkg::B_IDLE;
      end
    endcase
  end

  // cleared position
  always_ff @(posedge clk) begin
    if (rst) begin
      cleared <= '0;
    end else if (upd_cleared) begin
      cleared <= job.target;
    end
  end

  // job and wrap index holding
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_data;
    end
    if (upd_cleared) begin
      seg2_idx <= tgt_idx;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      seg_start    <= rbtc_pkg::START_W'(o_start);
      seg_length   <= rbtc_pkg::LEN_W'(o_len);
      behind       <= o_behind;
      last_segment <= o_last;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == rbtc_pkg::B_IDLE)
    else $error("job taken while a job is still in work");

  a_seg2_index: assert property (@(posedge clk) disable iff (rst)
    state == rbtc_pkg::B_SEG2 |-> cleared[rbtc_pkg::RING_W-1:0] == seg2_idx)
    else $error("second segment end differs from cleared index");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("segment written over an untaken beat");

endmodule

`default_nettype wire

### hdl/ring_buffer_trailing_clearer.sv
// Ring buffer trailing clearer.
// The in channel (in_valid/in_ready) takes one tick beat: now_time, origin_position,
// origin_time and sample_period. The block derives the playback target as
// origin_position + elapsed / sample_period - back_guard and answers with one or two
// segment beats on the out channel (out_valid/out_ready): a ring range to zero from
// the cleared point up to the target, split in two when it wraps the ring end, or an
// empty segment flagged behind when the target is over a ring ahead. back_guard is
// written over the cfg channel (cfg_valid/cfg_ready/cfg_data), ready whenever reset
// is low. A taken tick goes through the bit-serial divider, one quotient bit per
// cycle, then is pushed to the queue, popped by the back and written as a segment to
// the output register; a zero-period tick skips the divider. The front takes no new
// tick until its last job is pushed. A two-entry job queue sits between the divider
// front and the segment back, so the front keeps dividing the next tick while the back
// waits on a stalled receiver; with the queue full the front holds in_ready low.
// Segments sit in an output register until taken.
// Reset clears the cleared position to zero, sets back_guard to 64 and empties the
// queue and output register; no beat is taken while reset is high.
`default_nettype none

module ring_buffer_trailing_clearer (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [rbtc_pkg::GUARD_W-1:0]        cfg_data,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [rbtc_pkg::TIME_W-1:0]         now_time,
  input  wire  [rbtc_pkg::POS_W-1:0]          origin_position,
  input  wire  [rbtc_pkg::TIME_W-1:0]         origin_time,
  input  wire  [rbtc_pkg::PERIOD_W-1:0]       sample_period,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [rbtc_pkg::START_W-1:0]        seg_start,
  output logic [rbtc_pkg::LEN_W-1:0]          seg_length,
  output logic                                behind,
  output logic                                last_segment
);

  logic [rbtc_pkg::GUARD_W-1:0]      back_guard;
  logic                              q_push;
  logic                              q_pop;
  logic                              q_full;
  logic                              q_empty;
  rbtc_pkg::job_t                    q_wr;
  rbtc_pkg::job_t                    q_rd;

  assign cfg_ready = !rst;

  // guard register
  always_ff @(posedge clk) begin
    if (rst) begin
      back_guard <= rbtc_pkg::GUARD_RESET;
    end else if (cfg_valid) begin
      back_guard <= cfg_data;
    end
  end

  rbtc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .back_guard      (back_guard),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .now_time        (now_time),
    .origin_position (origin_position),
    .origin_time     (origin_time),
    .sample_period   (sample_period),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wr)
  );

  rbtc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  rbtc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_data       (q_rd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .seg_start    (seg_start),
    .seg_length   (seg_length),
    .behind       (behind),
    .last_segment (last_segment)
  );

endmodule

`default_nettype wire
